/* sv/tlv_pkg.sv */
package tlv_pkg;

	// Default depth of each per-link decoded-byte queue.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Number of redundant links.
	localparam int LINKS = 3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ESCAPE_CODE   = 2'd0;
	localparam logic [1:0] CFG_FILL_CODE     = 2'd1;
	localparam logic [1:0] CFG_FLIP_MASK     = 2'd2;
	localparam logic [1:0] CFG_DISAGREE_CODE = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] ESCAPE_CODE_RST   = 8'h7D;
	localparam logic [7:0] FILL_CODE_RST     = 8'h55;
	localparam logic [7:0] FLIP_MASK_RST     = 8'h20;
	localparam logic [7:0] DISAGREE_CODE_RST = 8'h3F;

	// Link index that names no link.
	localparam logic [1:0] LINK_NONE = 2'd3;

	// Terminal mark of a link.
	typedef enum logic [1:0] {
		TERM_NONE    = 2'd0,
		TERM_END     = 2'd1,
		TERM_CORRUPT = 2'd2
	} term_t;

	// Kind of a result beat.
	typedef enum logic [1:0] {
		KIND_VOTE     = 2'd0,
		KIND_FINISHED = 2'd1,
		KIND_CORRUPT  = 2'd2
	} kind_t;

endpackage

/* sv/tlv_fifo.sv */
module tlv_fifo #(
	parameter int DEPTH = tlv_pkg::QUEUE_DEPTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       push_data,
	input  logic             pop,
	output logic [7:0]       head,
	output logic [CNT_W-1:0] count
);

	logic [7:0]       mem [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       head_q;
	logic             empty;
	logic             eff_push;
	logic             eff_pop;
	logic [PTR_W-1:0] rd_ptr_next;
	logic [PTR_W-1:0] wr_ptr_inc;
	logic [PTR_W-1:0] rd_ptr_inc;

	// A push and a pop on an empty queue cancel: the byte is not stored.
	always_comb begin
		empty      = (count_q == '0);
		eff_pop    = pop && !empty;
		eff_push   = push && !(pop && empty);
		wr_ptr_inc = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		rd_ptr_inc = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		rd_ptr_next = eff_pop ? rd_ptr_inc : rd_ptr_q;
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (eff_push) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			rd_ptr_q <= rd_ptr_next;
			if (eff_push && !eff_pop) begin
				count_q <= count_q + 1'b1;
			end else if (eff_pop && !eff_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage with a prefetched head: the entry that will be at the front
	// next cycle is read now, bypassing a write to the same slot.
	always_ff @(posedge clk) begin
		if (eff_push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (eff_push && (wr_ptr_q == rd_ptr_next)) begin
			head_q <= push_data;
		end else begin
			head_q <= mem[rd_ptr_next];
		end
	end

	assign head  = head_q;
	assign count = count_q;

endmodule

/* sv/triple_link_unstuff_majority_voter_top.sv */
// Triple-link byte voter with per-link byte unstuffing. Raw bytes or end marks
// from three redundant links enter as beats on the input channel; each link
// drops fill bytes and unmasks the byte after an escape, and queues decoded
// bytes in its own FIFO of QUEUE_DEPTH entries. Once every link holds a byte
// or a terminal mark, one result beat is produced: a 2-of-3 majority byte (or
// the disagree code), finished, or a corrupt-stream error; after finished or
// an error the block ignores all input until reset. One input beat is taken
// every cycle, limited only by the result side holding off; a beat passes
// through the input register, and the result it causes is registered in the
// result register. Each FIFO has one write and one registered read port, with
// the head prefetched from the entry that will be at the front after a pop.
module triple_link_unstuff_majority_voter_top #(
	parameter int QUEUE_DEPTH = tlv_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] link_index,
	input  logic [7:0] raw_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] voted_byte,
	output logic       majority_found,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int NL    = tlv_pkg::LINKS;

	// Configuration registers.
	logic [7:0] escape_code_q;
	logic [7:0] fill_code_q;
	logic [7:0] flip_mask_q;
	logic [7:0] disagree_code_q;

	// Input register.
	logic       valid_s1;
	logic [1:0] link_s1;
	logic [7:0] raw_s1;
	logic       end_s1;

	// Per-link state.
	logic                  esc_pend_q [NL];
	tlv_pkg::term_t        term_q     [NL];
	logic                  halted_q;

	// Queue interface.
	logic                  q_push  [NL];
	logic                  q_pop   [NL];
	logic [7:0]            q_head  [NL];
	logic [CNT_W-1:0]      q_count [NL];

	// Result register.
	logic                  out_valid_q;
	tlv_pkg::kind_t        kind_q;
	logic [7:0]            voted_q;
	logic                  maj_q;

	// Processing signals.
	logic                  proc_en;
	logic                  hit        [NL];
	logic                  decoded    [NL];
	logic                  has_byte   [NL];
	logic                  link_rdy   [NL];
	logic [7:0]            front      [NL];
	logic                  esc_next   [NL];
	tlv_pkg::term_t        term_next  [NL];
	logic [7:0]            push_data;
	logic                  round;
	logic                  any_corrupt;
	logic                  any_end;
	logic                  halt_now;
	tlv_pkg::kind_t        kind_d;
	logic [7:0]            voted_d;
	logic                  maj_d;

	// The stage advances whenever the result register is free or draining.
	assign proc_en  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc_en;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_code_q   <= tlv_pkg::ESCAPE_CODE_RST;
			fill_code_q     <= tlv_pkg::FILL_CODE_RST;
			flip_mask_q     <= tlv_pkg::FLIP_MASK_RST;
			disagree_code_q <= tlv_pkg::DISAGREE_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tlv_pkg::CFG_ESCAPE_CODE:   escape_code_q   <= cfg_data;
				tlv_pkg::CFG_FILL_CODE:     fill_code_q     <= cfg_data;
				tlv_pkg::CFG_FLIP_MASK:     flip_mask_q     <= cfg_data;
				tlv_pkg::CFG_DISAGREE_CODE: disagree_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			link_s1 <= link_index;
			raw_s1  <= raw_byte;
			end_s1  <= stream_end;
		end
	end

	assign push_data = raw_s1 ^ (esc_pend_q[link_s1 == tlv_pkg::LINK_NONE ? 2'd0 : link_s1]
		? flip_mask_q : 8'h00);

	// Per-link unstuffing and readiness for a round.
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			hit[i] = proc_en && !halted_q && (link_s1 == 2'(i)) &&
				(term_q[i] == tlv_pkg::TERM_NONE);
			decoded[i] = hit[i] && !end_s1 && (esc_pend_q[i] ||
				((raw_s1 != escape_code_q) && (raw_s1 != fill_code_q)));
			q_push[i] = decoded[i] && (q_count[i] != CNT_W'(QUEUE_DEPTH));
			term_next[i] = term_q[i];
			esc_next[i]  = esc_pend_q[i];
			if (hit[i]) begin
				if (end_s1) begin
					term_next[i] = esc_pend_q[i] ? tlv_pkg::TERM_CORRUPT : tlv_pkg::TERM_END;
					esc_next[i]  = 1'b0;
				end else if (esc_pend_q[i]) begin
					esc_next[i] = 1'b0;
				end else begin
					esc_next[i] = (raw_s1 == escape_code_q);
				end
				if (decoded[i] && !q_push[i]) begin
					term_next[i] = tlv_pkg::TERM_CORRUPT;
				end
			end
			has_byte[i] = (q_count[i] != '0) || q_push[i];
			front[i]    = (q_count[i] == '0) ? push_data : q_head[i];
			link_rdy[i] = has_byte[i] || (term_next[i] != tlv_pkg::TERM_NONE);
		end
	end

	// Round resolution and vote.
	always_comb begin
		round       = hit[0] || hit[1] || hit[2];
		any_corrupt = 1'b0;
		any_end     = 1'b0;
		for (int i = 0; i < NL; i++) begin
			round = round && link_rdy[i];
			if (!has_byte[i] && (term_next[i] == tlv_pkg::TERM_CORRUPT)) begin
				any_corrupt = 1'b1;
			end
			if (!has_byte[i] && (term_next[i] == tlv_pkg::TERM_END)) begin
				any_end = 1'b1;
			end
		end
		halt_now = round && (any_corrupt || any_end);
		for (int i = 0; i < NL; i++) begin
			q_pop[i] = round && !(any_corrupt || any_end);
		end
		if (any_corrupt) begin
			kind_d  = tlv_pkg::KIND_CORRUPT;
			voted_d = 8'h00;
			maj_d   = 1'b0;
		end else if (any_end) begin
			kind_d  = tlv_pkg::KIND_FINISHED;
			voted_d = 8'h00;
			maj_d   = 1'b0;
		end else if ((front[0] == front[1]) || (front[1] == front[2])) begin
			kind_d  = tlv_pkg::KIND_VOTE;
			voted_d = front[1];
			maj_d   = 1'b1;
		end else if (front[0] == front[2]) begin
			kind_d  = tlv_pkg::KIND_VOTE;
			voted_d = front[2];
			maj_d   = 1'b1;
		end else begin
			kind_d  = tlv_pkg::KIND_VOTE;
			voted_d = disagree_code_q;
			maj_d   = 1'b0;
		end
	end

	// Per-link decoded-byte queues.
	for (genvar g = 0; g < NL; g++) begin : g_link
		tlv_fifo #(
			.DEPTH (QUEUE_DEPTH)
		) u_fifo (
			.clk       (clk),
			.arst_n    (arst_n),
			.push      (q_push[g]),
			.push_data (push_data),
			.pop       (q_pop[g]),
			.head      (q_head[g]),
			.count     (q_count[g])
		);
	end

	// Link state and halt flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				esc_pend_q[i] <= 1'b0;
				term_q[i]     <= tlv_pkg::TERM_NONE;
			end
			halted_q <= 1'b0;
		end else begin
			for (int i = 0; i < NL; i++) begin
				esc_pend_q[i] <= esc_next[i];
				term_q[i]     <= term_next[i];
			end
			if (halt_now) begin
				halted_q <= 1'b1;
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (round) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (round) begin
			kind_q  <= kind_d;
			voted_q <= voted_d;
			maj_q   <= maj_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign voted_byte     = voted_q;
	assign majority_found = maj_q;

`ifndef SYNTHESIS
	// Once halted, no further round may resolve.
	a_halt_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !round)
		else $error("round resolved while halted");

	// A finished or corrupt result halts the block in the next cycle.
	a_halt_follows: assert property (@(posedge clk) disable iff (!arst_n)
		halt_now |=> halted_q)
		else $error("halt flag not set after terminal result");

	// A round never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !round)
		else $error("result overwritten before it was taken");

	// At most one link is touched by a beat.
	a_one_link: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({hit[2], hit[1], hit[0]}))
		else $error("more than one link updated by one beat");

	// A pop only happens on a link that holds a byte.
	a_pop_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop[0] |-> (has_byte[0] && has_byte[1] && has_byte[2]))
		else $error("pop on a link without a byte");
`endif

endmodule
